// ===== src/nsr_pkg.sv =====
`timescale 1ns / 1ps
package nsr_pkg;

	localparam int VALUE_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ROOT_W     = 24;
	localparam int TOL_W      = 17;
	localparam int MAX_STEPS  = 64;
	localparam int SCALED_W   = VALUE_W + FRAC_BITS;
	localparam int GUESS_W    = SCALED_W;
	localparam int DIV_CNT_W  = $clog2(SCALED_W);
	localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);
	localparam int ADDR_W     = 3;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

	typedef logic [2:0] step_t;

	localparam step_t STEP_WAIT     = 3'd0;
	localparam step_t STEP_CLASS    = 3'd1;
	localparam step_t STEP_DIV_INIT = 3'd2;
	localparam step_t STEP_DIV_BIT  = 3'd3;
	localparam step_t STEP_UPDATE   = 3'd4;
	localparam step_t STEP_CHECK    = 3'd5;
	localparam step_t STEP_EMIT     = 3'd6;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_BIT,
		OP_UPDATE,
		OP_ADVANCE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_FIRE,
		COND_SPECIAL,
		COND_DIV_LAST,
		COND_FINISH,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump_t;
		step_t jump_f;
	} ctrl_word_t;

	// microprogram: the condition picks jump_t, otherwise jump_f
	function automatic ctrl_word_t rom_word(input step_t addr);
		ctrl_word_t cw;
		unique case (addr)
			STEP_WAIT:     cw = '{OP_LOAD,      COND_IN_FIRE,  STEP_CLASS,   STEP_WAIT};
			STEP_CLASS:    cw = '{OP_NONE,      COND_SPECIAL,  STEP_EMIT,    STEP_DIV_INIT};
			STEP_DIV_INIT: cw = '{OP_DIV_START, COND_ALWAYS,   STEP_DIV_BIT, STEP_DIV_BIT};
			STEP_DIV_BIT:  cw = '{OP_DIV_BIT,   COND_DIV_LAST, STEP_UPDATE,  STEP_DIV_BIT};
			STEP_UPDATE:   cw = '{OP_UPDATE,    COND_ALWAYS,   STEP_CHECK,   STEP_CHECK};
			STEP_CHECK:    cw = '{OP_ADVANCE,   COND_FINISH,   STEP_EMIT,    STEP_DIV_INIT};
			STEP_EMIT:     cw = '{OP_EMIT,      COND_OUT_BUSY, STEP_EMIT,    STEP_WAIT};
			default:       cw = '{OP_NONE,      COND_ALWAYS,   STEP_WAIT,    STEP_WAIT};
		endcase
		return cw;
	endfunction

endpackage

// ===== src/newton_square_root.sv =====
`timescale 1ns / 1ps
// channel      | dir | handshake               | payload
// s_axis       | in  | s_axis_tvalid/tready    | tdata[31:0] value (signed Q16.16)
// m_axis       | out | m_axis_tvalid/tready    | tdata[23:0] root, tuser[1:0] flags
// apb          | in  | psel/penable/pready     | reg 0 at 0x0: tolerance[16:0]
//
// Special operands (negative, zero, exactly 1.0) go from the class step straight to emit.
// Others run n Newton steps (n <= 64): each step starts and runs the
// shared restoring divider, one quotient bit a cycle, then updates and checks the guess.
// A new word is accepted only in the wait step; a held result does not stop that.
// A stalled output holds the sequencer in its emit step. arst_n clears control state.
module newton_square_root
	import nsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [ROOT_W-1:0]     m_axis_tdata,   // [23:0] root
	output logic [1:0]            m_axis_tuser,   // [0] invalid, [1] hit_limit
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic [GUESS_W-1:0]   ROOT_MAX = GUESS_W'({ROOT_W{1'b1}});
	localparam logic [VALUE_W-1:0]   ONE_FX   = VALUE_W'(1) << FRAC_BITS;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SCALED_W - 1);

	step_t                 pc_q;
	ctrl_word_t            cw;
	logic                  cond;
	logic                  in_fire;
	logic                  out_busy;
	logic [TOL_W-1:0]      tol_q;
	logic [VALUE_W-1:0]    raw_q;
	logic [GUESS_W-1:0]    last_q;
	logic [GUESS_W-1:0]    next_q;
	logic [STEP_CNT_W-1:0] steps_q;
	logic                  conv_q;
	logic [GUESS_W-1:0]    rem_q;
	logic [SCALED_W-1:0]   dq_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [GUESS_W-1:0]    divisor;
	logic [GUESS_W:0]      trial;
	logic [GUESS_W:0]      trial_diff;
	logic [GUESS_W:0]      upd_sum;
	logic [GUESS_W-1:0]    diff;
	logic                  done;
	logic                  special;
	logic                  out_valid_q;
	logic [ROOT_W-1:0]     out_root_q;
	logic                  out_inv_q;
	logic                  out_lim_q;
	logic [ROOT_W-1:0]     res_root;
	logic                  cfg_wr;

	assign cfg_wr        = psel && penable && pwrite && pready;
	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == 1'b0) ? 32'(tol_q) : 32'd0;

	assign cw            = rom_word(pc_q);
	assign s_axis_tready = (pc_q == STEP_WAIT);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_busy      = out_valid_q && !m_axis_tready;

	assign special = raw_q[VALUE_W-1] || (raw_q == '0) || (raw_q == ONE_FX);
	assign divisor = (last_q == '0) ? GUESS_W'(1) : last_q;
	assign trial      = {rem_q, dq_q[SCALED_W-1]};
	assign trial_diff = trial - {1'b0, divisor};
	assign upd_sum    = {1'b0, last_q} + {1'b0, dq_q};
	assign diff       = (last_q > next_q) ? (last_q - next_q) : (next_q - last_q);
	assign done       = diff <= GUESS_W'(tol_q);

	always_comb begin
		unique case (cw.cond)
			COND_ALWAYS:   cond = 1'b1;
			COND_IN_FIRE:  cond = in_fire;
			COND_SPECIAL:  cond = special;
			COND_DIV_LAST: cond = (cnt_q == DIV_LAST);
			COND_FINISH:   cond = done || (steps_q >= STEP_CNT_W'(MAX_STEPS));
			COND_OUT_BUSY: cond = out_busy;
			default:       cond = 1'b1;
		endcase
	end

	always_comb begin
		if (raw_q[VALUE_W-1]) begin
			res_root = '0;
		end else if (special) begin
			res_root = raw_q[ROOT_W-1:0];
		end else if (next_q > ROOT_MAX) begin
			res_root = ROOT_MAX[ROOT_W-1:0];
		end else begin
			res_root = next_q[ROOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_WAIT;
			tol_q       <= TOL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond ? cw.jump_t : cw.jump_f;
			if (cfg_wr && paddr[2] == 1'b0) begin
				tol_q <= pwdata[TOL_W-1:0];
			end
			if (cw.op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath driven by the current control word
	always_ff @(posedge clk) begin
		case (cw.op)
			OP_LOAD: begin
				if (in_fire) begin
					raw_q   <= s_axis_tdata;
					last_q  <= GUESS_W'(s_axis_tdata);
					steps_q <= '0;
				end
			end
			OP_DIV_START: begin
				rem_q <= '0;
				dq_q  <= {raw_q, {FRAC_BITS{1'b0}}};
				cnt_q <= '0;
			end
			OP_DIV_BIT: begin
				if (!trial_diff[GUESS_W]) begin
					rem_q <= trial_diff[GUESS_W-1:0];
				end else begin
					rem_q <= trial[GUESS_W-1:0];
				end
				dq_q  <= {dq_q[SCALED_W-2:0], !trial_diff[GUESS_W]};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			OP_UPDATE: begin
				next_q  <= upd_sum[GUESS_W:1];
				steps_q <= steps_q + STEP_CNT_W'(1);
			end
			OP_ADVANCE: begin
				last_q <= next_q;
				conv_q <= done;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_root_q <= res_root;
					out_inv_q  <= raw_q[VALUE_W-1];
					out_lim_q  <= !special && !conv_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_root_q;
	assign m_axis_tuser  = {out_lim_q, out_inv_q};

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q == STEP_EMIT))
		else $error("result raised outside the emit step");

	a_invalid_root: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_inv_q) |-> (out_root_q == '0 && !out_lim_q))
		else $error("invalid result with nonzero root or limit flag");

	a_step_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_CHECK) |-> (steps_q <= STEP_CNT_W'(MAX_STEPS)))
		else $error("Newton step count above the cap");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_UPDATE) |-> (cnt_q == DIV_CNT_W'(0) + DIV_LAST + DIV_CNT_W'(1)
			|| $past(cnt_q) == DIV_LAST))
		else $error("division left before its last bit");

endmodule

// ===== sim/newton_square_root_tb.sv =====
`timescale 1ns / 1ps
module newton_square_root_tb;
	import nsr_pkg::*;

	localparam logic [ADDR_W-1:0] TOL_ADDR   = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);   // index 1: no register there
	localparam int                LONG_HOLD  = 2000;
	localparam int                SETTLE     = 8;
	localparam int                MAX_SHOWN  = 10;
	localparam logic [63:0]       ROOT_MAX   = (64'd1 << ROOT_W) - 1;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              invalid;
		logic              hit_limit;
	} root_word_t;

	typedef struct packed {
		logic               typed;
		logic [VALUE_W-1:0] value;
		root_word_t         want;
	} stim_row_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [VALUE_W-1:0] s_axis_tdata  = '0;   // [31:0] value
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [ROOT_W-1:0]  m_axis_tdata;         // [23:0] root
	logic [1:0]         m_axis_tuser;         // [0] invalid, [1] hit_limit
	logic               psel          = 1'b0;
	logic               penable       = 1'b0;
	logic               pwrite        = 1'b0;
	logic [ADDR_W-1:0]  paddr         = '0;
	logic [31:0]        pwdata        = '0;
	logic [31:0]        prdata;
	logic               pready;

	root_word_t         expected_roots [$];
	stim_row_t          directed_rows [16];
	logic [TOL_W-1:0]   tol_shadow    = TOL_RESET;
	bit                 no_idle       = 1'b0;
	bit                 hold_req      = 1'b0;
	int                 mismatches    = 0;
	int                 operands_sent = 0;
	int                 results_seen  = 0;
	int                 negatives     = 0;
	int                 caps_seen     = 0;
	int                 settings_used = 0;

	newton_square_root DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic root_word_t predict_root(input logic [VALUE_W-1:0] value,
			input logic [TOL_W-1:0] tol);
		root_word_t  r;
		logic [63:0] scaled, last, next, diff;
		int          steps;
		r = '0;
		if (value[VALUE_W-1]) begin
			r.invalid = 1'b1;
		end else if (value == '0 || value == (VALUE_W'(1) << FRAC_BITS)) begin
			r.root = ROOT_W'(value);
		end else begin
			scaled = 64'(value) << FRAC_BITS;
			next   = 64'(value);
			steps  = 0;
			do begin
				last  = next;
				// a zero guess divides by one instead
				next  = (last + scaled / ((last == 64'd0) ? 64'd1 : last)) >> 1;
				diff  = (last > next) ? last - next : next - last;
				steps = steps + 1;
			end while (diff > 64'(tol) && steps < MAX_STEPS);
			r.hit_limit = (diff > 64'(tol));
			r.root      = (next > ROOT_MAX) ? '1 : ROOT_W'(next);
		end
		return r;
	endfunction

	function automatic logic [VALUE_W-1:0] rand_operand(input int band);
		logic [63:0]        m;
		logic [VALUE_W-1:0] v;
		if (band < 10) begin
			case ($urandom_range(0, 5))
				0:       v = '0;
				1:       v = VALUE_W'(1) << FRAC_BITS;
				2:       v = (VALUE_W'(1) << FRAC_BITS) + VALUE_W'($urandom_range(0, 2)) - 1;
				3:       v = {1'b0, {(VALUE_W-1){1'b1}}};
				4:       v = VALUE_W'(1);
				default: begin
					m = 64'($urandom_range(1, 46340));
					v = VALUE_W'(m * m);
				end
			endcase
		end else if (band < 15) begin
			// scaled operand one short of a square: the guess swaps between two neighbours
			m = 64'($urandom_range(1, 361)) * (64'd1 << (FRAC_BITS - 1));
			m = $urandom_range(0, 1) ? m + 64'd1 : m - 64'd1;
			v = VALUE_W'((m * m - 64'd1) >> FRAC_BITS);
		end else if (band < 30) begin
			v = $urandom;
		end else if (band < 40) begin
			v = $urandom | 32'h8000_0000;
		end else begin
			v = $urandom >> $urandom_range(1, VALUE_W - 1);
		end
		return v;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic apb_cycle(input bit wr, input logic [ADDR_W-1:0] addr,
			input logic [31:0] data, output logic [31:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		logic [31:0] rd;
		apb_cycle(1'b1, addr, data, rd);
		if (addr == TOL_ADDR) begin
			tol_shadow = data[TOL_W-1:0];
			settings_used++;
		end
		apb_cycle(1'b0, TOL_ADDR, '0, rd);
		if (rd !== 32'(tol_shadow))
			flag_error($sformatf("tolerance reads %h, expected %h", rd, 32'(tol_shadow)));
	endtask

	task automatic send_operand(input logic [VALUE_W-1:0] value, input bit typed,
			input root_word_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		expected_roots.push_back(typed ? want : predict_root(value, tol_shadow));
		operands_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_roots.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] tol, input int count);
		drain_results();
		write_register(TOL_ADDR, tol);
		no_idle = ($urandom_range(0, 3) == 0);
		repeat (count) send_operand(rand_operand($urandom_range(0, 99)), 1'b0, '0);
	endtask

	initial begin : stimulus
		logic [31:0] tol;
		// typed, value, root, invalid, hit_limit
		directed_rows = '{
			{1'b1, 32'h0000_0000, 24'h00_0000, 1'b0, 1'b0},   // zero passes through
			{1'b1, 32'h0001_0000, 24'h01_0000, 1'b0, 1'b0},   // one passes through
			{1'b1, 32'h8000_0000, 24'h00_0000, 1'b1, 1'b0},   // most negative
			{1'b1, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, 1'b0},   // least negative
			{1'b1, 32'hAAAA_AAAA, 24'h00_0000, 1'b1, 1'b0},
			{1'b0, 32'h0000_0001, 24'h00_0000, 1'b0, 1'b0},   // smallest positive
			{1'b0, 32'h0000_FFFF, 24'h00_0000, 1'b0, 1'b0},   // just under one
			{1'b0, 32'h0001_0001, 24'h00_0000, 1'b0, 1'b0},   // just over one
			{1'b0, 32'h7FFF_FFFF, 24'h00_0000, 1'b0, 1'b0},   // largest
			{1'b0, 32'h0000_0002, 24'h00_0000, 1'b0, 1'b0},
			{1'b0, 32'h0004_0000, 24'h00_0000, 1'b0, 1'b0},
			{1'b0, 32'h0090_0000, 24'h00_0000, 1'b0, 1'b0},
			{1'b0, 32'h4000_0000, 24'h00_0000, 1'b0, 1'b0},
			{1'b0, 32'h5555_5555, 24'h00_0000, 1'b0, 1'b0},
			{1'b0, 32'h7FFF_0000, 24'h00_0000, 1'b0, 1'b0},
			{1'b0, 32'h0000_8000, 24'h00_0000, 1'b0, 1'b0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tolerance left at its reset value
		foreach (directed_rows[n])
			send_operand(directed_rows[n].value, directed_rows[n].typed, directed_rows[n].want);
		run_phase(32'd1, 40);

		// only an equal pair stops the loop; swapping operands run into the cap
		drain_results();
		write_register(TOL_ADDR, 32'hFFFE_0000);
		send_operand(32'h0000_4001, 1'b0, '0);
		send_operand(32'h0000_3FFF, 1'b0, '0);
		send_operand(32'h0000_FFFE, 1'b0, '0);
		send_operand(32'h0001_0002, 1'b0, '0);
		repeat (6) send_operand(rand_operand($urandom_range(10, 14)), 1'b0, '0);
		repeat (4) send_operand(rand_operand($urandom_range(0, 99)), 1'b0, '0);

		run_phase(32'd65536, 60);

		// hold the output off so the input backs up
		no_idle  = 1'b1;
		hold_req = 1'b1;
		repeat (8) send_operand(rand_operand($urandom_range(40, 99)), 1'b0, '0);

		drain_results();
		write_register(SPARE_ADDR, 32'h0000_0123);
		repeat (20) send_operand(rand_operand($urandom_range(0, 99)), 1'b0, '0);

		run_phase(32'hFFFF_FFFF, 60);

		repeat (12) begin
			case ($urandom_range(0, 3))
				0:       tol = 32'd1;
				1:       tol = $urandom_range(2, 16);
				2:       tol = $urandom_range(17, 4096);
				default: tol = $urandom_range(4097, 65536);
			endcase
			run_phase(tol, 65);
		end
		drain_results();

		$display("%0d operands through %0d tolerance settings, %0d results compared.",
			operands_sent, settings_used, results_seen);
		$display("%0d negative operands flagged, %0d iterations stopped at the step cap.",
			negatives, caps_seen);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : result_check
		root_word_t got, want;
		int         gap;
		wait (arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (hold_req) begin
				gap      = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!m_axis_tvalid);
			got.root      = m_axis_tdata;
			got.invalid   = m_axis_tuser[0];
			got.hit_limit = m_axis_tuser[1];
			results_seen++;
			negatives += got.invalid;
			caps_seen += got.hit_limit;
			if (expected_roots.size() == 0) begin
				flag_error($sformatf("result word with nothing expected: root %h flags %b",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = expected_roots.pop_front();
				if (got.root !== want.root)
					flag_error($sformatf("root %h, expected %h", got.root, want.root));
				if (got.invalid !== want.invalid)
					flag_error($sformatf("invalid %b, expected %b (root %h)",
						got.invalid, want.invalid, want.root));
				if (got.hit_limit !== want.hit_limit)
					flag_error($sformatf("hit_limit %b, expected %b (root %h)",
						got.hit_limit, want.hit_limit, want.root));
			end
		end
	end

	// this allows several times the slowest legal run
	initial begin : watchdog
		#250_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
